/* sv/dps_pkg.sv */
// Shared types and constants for the delimiter pattern splitter.
`timescale 1ns / 1ps

package dps_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    localparam int CFG_DATA_W = 64;
    localparam int LEN_RAW_W  = 4;
    localparam int CNT_OUT_W  = 16;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_BOUND = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       string_end;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_slot;

endpackage

/* sv/dps_in_if.sv */
// Input channel: one string byte and its end flag per item.
`timescale 1ns / 1ps

interface dps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       string_end;

    modport source (output valid, in_byte, has_byte, string_end, input ready);
    modport sink   (input valid, in_byte, has_byte, string_end, output ready);
endinterface

/* sv/dps_out_if.sv */
// Output channel: one data byte, element boundary or end-of-string result per item.
`timescale 1ns / 1ps

interface dps_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [15:0] element_count;
    logic        last;

    modport source (output valid, out_byte, kind, element_count, last, input ready);
    modport sink   (input valid, out_byte, kind, element_count, last, output ready);
endinterface

/* sv/dps_front.sv */
// Front end: accepts input items, drops empty ones, forwards the rest to the queue.
`timescale 1ns / 1ps

module dps_front import dps_pkg::*; (
    input  logic   i_rst_n,
    dps_in_if.sink i_in,
    input  logic   i_full,
    output t_slot  o_push
);

    always_comb begin
        i_in.ready = i_rst_n && !i_full;
        o_push.cmd.in_byte    = i_in.in_byte;
        o_push.cmd.has_byte   = i_in.has_byte;
        o_push.cmd.string_end = i_in.string_end;
        // an item with neither byte nor end does nothing: drop it here
        o_push.valid = i_in.valid && i_in.ready && (i_in.has_byte || i_in.string_end);
    end

endmodule

/* sv/dps_queue.sv */
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module dps_queue import dps_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_slot i_push,
    input  logic  i_pop,
    output t_slot o_head,
    output logic  o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.valid) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign o_full       = (r_count == CW'(DEPTH));

endmodule

/* sv/dps_back.sv */
// Back end: lookahead window, pattern compare, one decision or flush step per cycle while the output is not stalled.
`timescale 1ns / 1ps

module dps_back import dps_pkg::*; #(
    parameter int PATTERN_MAX = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_pattern,
    input  logic [LEN_RAW_W-1:0]  i_len_raw,
    input  t_slot                 i_head,
    output logic                  o_pop,
    dps_out_if.source             o_out
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // window state
    logic [7:0]             r_win [PATTERN_MAX];
    logic [7:0]             n_win [PATTERN_MAX];
    logic [LW-1:0]          r_fill, n_fill;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_seen, n_seen;
    // byte of the head item already sits in the window
    logic                   r_app, n_app;

    // output register
    logic                   r_ovalid, n_ovalid;
    logic [7:0]             r_obyte, n_obyte;
    t_kind                  r_okind, n_okind;
    logic [CNT_OUT_W-1:0]   r_ocnt, n_ocnt;
    logic                   r_olast, n_olast;

    logic [LW-1:0]          eff_len;
    logic                   do_app;
    logic [7:0]             cw [PATTERN_MAX];
    logic [LW-1:0]          cf;
    logic                   seen_eff;
    logic                   win_match;
    logic [7:0]             sh_len [PATTERN_MAX];
    logic [7:0]             sh_one [PATTERN_MAX];
    logic [COUNT_WIDTH-1:0] fin_cnt;
    logic [31:0]            fin_cnt32;
    logic                   emit;
    logic                   pop;
    logic                   can_emit;
    logic                   step;

    always_comb begin
        if (i_len_raw == '0) begin
            eff_len = LW'(1);
        end else if (i_len_raw > LEN_RAW_W'(PATTERN_MAX)) begin
            eff_len = LW'(PATTERN_MAX);
        end else begin
            eff_len = LW'(i_len_raw);
        end
    end

    // window as it stands with the head item's byte appended
    always_comb begin
        do_app   = i_head.cmd.has_byte && !r_app && (r_fill < LW'(PATTERN_MAX));
        cf       = r_fill + LW'(do_app);
        seen_eff = r_seen || (i_head.cmd.has_byte && !r_app);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            cw[i] = (do_app && (r_fill == LW'(i))) ? i_head.cmd.in_byte : r_win[i];
        end
    end

    always_comb begin
        win_match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((LW'(i) < eff_len) && (cw[i] != i_pattern[8*i +: 8])) begin
                win_match = 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            sh_len[i] = '0;
            sh_one[i] = (i + 1 < PATTERN_MAX) ? cw[(i + 1) % PATTERN_MAX] : 8'd0;
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (32'(j) == 32'(i) + 32'(eff_len)) begin
                    sh_len[i] = cw[j];
                end
            end
        end
    end

    always_comb begin
        if (!seen_eff) begin
            fin_cnt = '0;
        end else if (r_cnt == CNT_MAX) begin
            fin_cnt = CNT_MAX;
        end else begin
            fin_cnt = r_cnt + 1'b1;
        end
        fin_cnt32 = 32'(fin_cnt);
    end

    always_comb begin
        n_win   = cw;
        n_fill  = cf;
        n_cnt   = r_cnt;
        n_seen  = seen_eff;
        n_obyte = '0;
        n_okind = KIND_DATA;
        n_ocnt  = '0;
        n_olast = 1'b0;
        emit    = 1'b0;
        pop     = 1'b0;
        if (i_head.cmd.has_byte && (cf >= eff_len)) begin
            emit = 1'b1;
            if (win_match) begin
                n_okind = KIND_BOUND;
                n_win   = sh_len;
                n_fill  = cf - eff_len;
                if (r_cnt != CNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end else begin
                n_obyte = cw[0];
                n_win   = sh_one;
                n_fill  = cf - 1'b1;
            end
            // keep deciding while a shorter length leaves a full window
            pop     = (n_fill < eff_len) && !i_head.cmd.string_end;
            n_olast = pop;
        end else if (i_head.cmd.string_end) begin
            emit = 1'b1;
            if (cf != '0) begin
                // flush the oldest pending byte
                n_obyte = cw[0];
                n_win   = sh_one;
                n_fill  = cf - 1'b1;
            end else begin
                n_okind = KIND_END;
                n_ocnt  = fin_cnt32[CNT_OUT_W-1:0];
                n_olast = 1'b1;
                pop     = 1'b1;
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    n_win[i] = '0;
                end
                n_fill = '0;
                n_cnt  = '0;
                n_seen = 1'b0;
            end
        end else begin
            pop = 1'b1;
        end
        n_app = !pop;
    end

    always_comb begin
        can_emit = !r_ovalid || o_out.ready;
        step     = i_head.valid && (!emit || can_emit);
        o_pop    = step && pop;
        if (step && emit) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_win[i] <= '0;
            end
            r_fill   <= '0;
            r_cnt    <= '0;
            r_seen   <= 1'b0;
            r_app    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (step) begin
                r_win  <= n_win;
                r_fill <= n_fill;
                r_cnt  <= n_cnt;
                r_seen <= n_seen;
                r_app  <= n_app;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_obyte <= n_obyte;
            r_okind <= n_okind;
            r_ocnt  <= n_ocnt;
            r_olast <= n_olast;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.out_byte      = r_obyte;
    assign o_out.kind          = r_okind;
    assign o_out.element_count = r_ocnt;
    assign o_out.last          = r_olast;

endmodule

/* sv/delimiter_pattern_splitter_top.sv */
// Top level of the delimiter pattern splitter: config registers, front, queue, back.
//
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     in_byte[8], has_byte, string_end
//  o_out     out  valid/ready     out_byte[8], kind[2], element_count[16], last
//  i_cfg_*   in   write enable    i_cfg_idx[1], i_cfg_data[64]
//
// A byte stream runs at one item per cycle while the output is not stalled.
// An end-of-string item flushes each pending window byte (at most pattern length - 1) in turn
// and then emits the count; after a shorter pattern length an item stays until its decisions are done.
// The back end makes one decision or flush step per cycle while the output is not stalled; the queue holds four items.
// Reset is synchronous; ready stays low while reset is held and clears all string state.
// A stalled output holds its register; the queue keeps taking items until it is full.
`timescale 1ns / 1ps

module delimiter_pattern_splitter_top import dps_pkg::*; #(
    parameter int PATTERN_MAX = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dps_in_if.sink                i_in,
    dps_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_pattern;
    logic [LEN_RAW_W-1:0]  r_len;

    t_slot push;
    t_slot head;
    logic  full;
    logic  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= LEN_RAW_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PATTERN_BYTES:  r_pattern <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_len     <= i_cfg_data[LEN_RAW_W-1:0];
                default: ;
            endcase
        end
    end

    dps_front u_front (
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    dps_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    dps_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pattern (r_pattern),
        .i_len_raw (r_len),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* sv/dps_checker.sv */
// Port-level assertions for the splitter and the bind that attaches them.
`timescale 1ns / 1ps

module dps_checker import dps_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [7:0]  i_byte,
    input logic [1:0]  i_kind,
    input logic [15:0] i_count,
    input logic        i_last
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

    // end of string always closes the item's results
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_kind == KIND_END)) |-> i_last)
        else $error("end of string without last");

    // only the end result carries a count, only data carries a byte
    a_clean_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_kind == KIND_END) || (i_count == '0))
                 && ((i_kind == KIND_DATA) || (i_byte == '0)))
        else $error("stray payload bits");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid && $stable(i_byte) && $stable(i_kind)
                                  && $stable(i_count) && $stable(i_last))
        else $error("stalled result changed");

endmodule

bind delimiter_pattern_splitter_top dps_checker u_dps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_byte  (o_out.out_byte),
    .i_kind  (o_out.kind),
    .i_count (o_out.element_count),
    .i_last  (o_out.last)
);
